// ----- sv/jfdc_pkg.sv -----
`default_nettype none

package jfdc_pkg;

    // Pipeline depth from the accepting register to the result register.
    localparam int STAGES = 6;

    localparam int PCT_BITS = 8;
    localparam int DZ_BITS  = 7;
    localparam int DIR_BITS = 3;

    localparam logic [DZ_BITS-1:0] DZ_RESET = 7'd20;
    localparam logic [PCT_BITS-1:0] PCT_FULL = 8'd100;

    localparam logic [DIR_BITS-1:0] DIR_CENTRE  = 3'd0;
    localparam logic [DIR_BITS-1:0] DIR_FORWARD = 3'd1;
    localparam logic [DIR_BITS-1:0] DIR_BACK    = 3'd2;
    localparam logic [DIR_BITS-1:0] DIR_RIGHT   = 3'd3;
    localparam logic [DIR_BITS-1:0] DIR_LEFT    = 3'd4;

    // take[i] is high when a real request moves into stage i.
    typedef struct packed {
        logic              prime;
        logic [STAGES-1:0] take;
    } jfdc_ctl_t;

endpackage

`default_nettype wire

// ----- sv/jfdc_lane.sv -----
`default_nettype none

module jfdc_lane
    import jfdc_pkg::*;
#(
    parameter int TAPS        = 8,
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                       clk,
    input  wire jfdc_ctl_t                  ctl,
    input  wire logic [SAMPLE_BITS-1:0]     sample,
    output logic      [SAMPLE_BITS-1:0]     filtered,
    output logic signed [PCT_BITS-1:0]      percent
);

    localparam int TAP_BITS  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + TAP_BITS;
    localparam int DIV_SHIFT = SUM_BITS + TAP_BITS;
    localparam longint unsigned DIV_MUL =
        ((64'd1 << DIV_SHIFT) + 64'(TAPS) - 64'd1) / 64'(TAPS);
    localparam int DIV_MUL_BITS = SUM_BITS + 1;
    localparam int PROD_BITS    = SUM_BITS + DIV_MUL_BITS;

    localparam int HALF        = ((1 << SAMPLE_BITS) - 1) / 2;
    localparam int SCALED_BITS = SAMPLE_BITS + 7;
    localparam int HALF_BITS   = $clog2(HALF);
    localparam int PCT_SHIFT   = SCALED_BITS + HALF_BITS;
    localparam longint unsigned PCT_MUL =
        ((64'd1 << PCT_SHIFT) + 64'(HALF) - 64'd1) / 64'(HALF);
    localparam int PCT_MUL_BITS = SCALED_BITS + 1;
    localparam int QPROD_BITS   = SCALED_BITS + PCT_MUL_BITS;

    localparam logic [SAMPLE_BITS-1:0] HALF_V = SAMPLE_BITS'(HALF);

    logic [SAMPLE_BITS-1:0] hist_reg  [TAPS];
    logic [SAMPLE_BITS-1:0] hist_next [TAPS];
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;

    logic [PROD_BITS-1:0]   prod_reg;

    logic [SAMPLE_BITS-1:0] filt2_reg;
    logic                   neg2_reg;
    logic [SCALED_BITS-1:0] scaled_reg;
    logic [SAMPLE_BITS-1:0] filt_w;
    logic                   neg_w;
    logic [SAMPLE_BITS-1:0] mag_w;

    logic [QPROD_BITS-1:0]  qprod_reg;
    logic [SAMPLE_BITS-1:0] filt3_reg;
    logic                   neg3_reg;

    logic [PCT_BITS-1:0]    quot_w;
    logic [PCT_BITS-1:0]    clamp_w;
    logic [SAMPLE_BITS-1:0] filt4_reg;
    logic [PCT_BITS-1:0]    pct_reg;

    // The oldest sample drops out of the running sum as the new one enters.
    // Priming loads every tap with the first sample.
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            if (ctl.prime || i == 0)
            begin
                hist_next[i] = sample;
            end
            else
            begin
                hist_next[i] = hist_reg[i-1];
            end
        end
        if (ctl.prime)
        begin
            sum_next = SUM_BITS'(sample) * SUM_BITS'(TAPS);
        end
        else
        begin
            sum_next = sum_reg - SUM_BITS'(hist_reg[TAPS-1]) + SUM_BITS'(sample);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take[0])
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
            sum_reg <= sum_next;
        end
    end

    // Division by the tap count as a multiplication by its rounded-up reciprocal.
    always_ff @(posedge clk)
    begin
        if (ctl.take[1])
        begin
            prod_reg <= PROD_BITS'(sum_reg) * PROD_BITS'(DIV_MUL);
        end
    end

    always_comb
    begin
        filt_w = prod_reg[DIV_SHIFT +: SAMPLE_BITS];
        neg_w  = (filt_w < HALF_V);
        if (neg_w)
        begin
            mag_w = HALF_V - filt_w;
        end
        else
        begin
            mag_w = filt_w - HALF_V;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take[2])
        begin
            filt2_reg  <= filt_w;
            neg2_reg   <= neg_w;
            scaled_reg <= SCALED_BITS'(mag_w) * SCALED_BITS'(100);
        end
    end

    // Magnitude divided by the half scale, so the sign truncates toward zero.
    always_ff @(posedge clk)
    begin
        if (ctl.take[3])
        begin
            qprod_reg <= QPROD_BITS'(scaled_reg) * QPROD_BITS'(PCT_MUL);
            filt3_reg <= filt2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    always_comb
    begin
        quot_w = qprod_reg[PCT_SHIFT +: PCT_BITS];
        if (quot_w > PCT_FULL)
        begin
            clamp_w = PCT_FULL;
        end
        else
        begin
            clamp_w = quot_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take[4])
        begin
            filt4_reg <= filt3_reg;
            pct_reg   <= neg3_reg ? (PCT_BITS'(0) - clamp_w) : clamp_w;
        end
    end

    assign filtered = filt4_reg;
    assign percent  = $signed(pct_reg);

endmodule

`default_nettype wire

// ----- sv/jfdc_merge.sv -----
`default_nettype none

module jfdc_merge
    import jfdc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire jfdc_ctl_t              ctl,
    input  wire logic [DZ_BITS-1:0]     deadzone,
    input  wire logic [SAMPLE_BITS-1:0] x_filt,
    input  wire logic [SAMPLE_BITS-1:0] y_filt,
    input  wire logic signed [PCT_BITS-1:0] x_pct,
    input  wire logic signed [PCT_BITS-1:0] y_pct,
    output logic [SAMPLE_BITS-1:0]      x_filtered,
    output logic [SAMPLE_BITS-1:0]      y_filtered,
    output logic signed [PCT_BITS-1:0]  x_tilt,
    output logic signed [PCT_BITS-1:0]  y_tilt,
    output logic [DIR_BITS-1:0]         direction,
    output logic                        direction_changed
);

    logic [DZ_BITS-1:0]     ax;
    logic [DZ_BITS-1:0]     ay;
    logic [DIR_BITS-1:0]    dir_next;
    logic [DIR_BITS-1:0]    last_dir_reg;
    logic [SAMPLE_BITS-1:0] x_filt_reg;
    logic [SAMPLE_BITS-1:0] y_filt_reg;
    logic [PCT_BITS-1:0]    x_pct_reg;
    logic [PCT_BITS-1:0]    y_pct_reg;
    logic [DIR_BITS-1:0]    dir_reg;
    logic                   changed_reg;

    // Percentages never exceed 100 in magnitude, so seven bits hold them.
    always_comb
    begin
        ax = x_pct[PCT_BITS-1] ? DZ_BITS'(-x_pct) : DZ_BITS'(x_pct);
        ay = y_pct[PCT_BITS-1] ? DZ_BITS'(-y_pct) : DZ_BITS'(y_pct);
        // The vertical axis wins ties; a zero deadzone makes a zero pair forward.
        priority if (ax < deadzone && ay < deadzone)
        begin
            dir_next = DIR_CENTRE;
        end
        else if (ay >= ax && ay >= deadzone)
        begin
            dir_next = y_pct[PCT_BITS-1] ? DIR_BACK : DIR_FORWARD;
        end
        else if (ax > ay && ax >= deadzone)
        begin
            dir_next = x_pct[PCT_BITS-1] ? DIR_LEFT : DIR_RIGHT;
        end
        else
        begin
            dir_next = DIR_CENTRE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_dir_reg <= DIR_CENTRE;
        end
        else if (ctl.take[STAGES-1])
        begin
            last_dir_reg <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take[STAGES-1])
        begin
            x_filt_reg  <= x_filt;
            y_filt_reg  <= y_filt;
            x_pct_reg   <= x_pct;
            y_pct_reg   <= y_pct;
            dir_reg     <= dir_next;
            changed_reg <= (dir_next != last_dir_reg);
        end
    end

    assign x_filtered        = x_filt_reg;
    assign y_filtered        = y_filt_reg;
    assign x_tilt            = $signed(x_pct_reg);
    assign y_tilt            = $signed(y_pct_reg);
    assign direction         = dir_reg;
    assign direction_changed = changed_reg;

endmodule

`default_nettype wire

// ----- sv/joystick_filter_direction_classifier.sv -----
// A request accepted into the running-sum stage moves through the stages in order and
// has its result on the outputs once the classification stage has registered it.
// Throughput: one sample pair per cycle without back-pressure; the six-stage pipeline
// (running sum, reciprocal divide by the tap count, scaling, reciprocal divide by the
// half scale, sign and clamp, classification) holds one request per stage.
// Reset clears the pipeline valid bits, the priming flag, the previous direction
// and sets the deadzone to 20; the tap history is filled by the first request.
`default_nettype none

module joystick_filter_direction_classifier
    import jfdc_pkg::*;
#(
    parameter int TAPS        = 8,
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [SAMPLE_BITS-1:0]     x_sample,
    input  wire logic [SAMPLE_BITS-1:0]     y_sample,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [DZ_BITS-1:0]         deadzone_percent,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [SAMPLE_BITS-1:0]          x_filtered,
    output logic [SAMPLE_BITS-1:0]          y_filtered,
    output logic signed [PCT_BITS-1:0]      x_tilt,
    output logic signed [PCT_BITS-1:0]      y_tilt,
    output logic [DIR_BITS-1:0]             direction,
    output logic                            direction_changed
);

    logic [STAGES-1:0]      valid_reg;
    logic [STAGES-1:0]      valid_next;
    logic [STAGES-1:0]      ld;
    logic                   primed_reg;
    logic [DZ_BITS-1:0]     deadzone_reg;
    jfdc_ctl_t              ctl;

    logic [SAMPLE_BITS-1:0] x_filt;
    logic [SAMPLE_BITS-1:0] y_filt;
    logic signed [PCT_BITS-1:0] x_pct;
    logic signed [PCT_BITS-1:0] y_pct;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        ld[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ld[i] = !valid_reg[i] || ld[i+1];
        end
        ctl.prime   = !primed_reg;
        ctl.take[0] = in_valid && ld[0];
        valid_next[0] = ld[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            ctl.take[i]   = ld[i] && valid_reg[i-1];
            valid_next[i] = ld[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            primed_reg   <= 1'b0;
            deadzone_reg <= DZ_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.take[0])
            begin
                primed_reg <= 1'b1;
            end
            if (cfg_valid)
            begin
                deadzone_reg <= deadzone_percent;
            end
        end
    end

    assign in_ready  = ld[0];
    assign cfg_ready = 1'b1;
    assign out_valid = valid_reg[STAGES-1];

    jfdc_lane #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_x (
        .clk      (clk),
        .ctl      (ctl),
        .sample   (x_sample),
        .filtered (x_filt),
        .percent  (x_pct)
    );

    jfdc_lane #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_y (
        .clk      (clk),
        .ctl      (ctl),
        .sample   (y_sample),
        .filtered (y_filt),
        .percent  (y_pct)
    );

    jfdc_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .deadzone          (deadzone_reg),
        .x_filt            (x_filt),
        .y_filt            (y_filt),
        .x_pct             (x_pct),
        .y_pct             (y_pct),
        .x_filtered        (x_filtered),
        .y_filtered        (y_filtered),
        .x_tilt            (x_tilt),
        .y_tilt            (y_tilt),
        .direction         (direction),
        .direction_changed (direction_changed)
    );

endmodule

`default_nettype wire
